### rtl/bnrq_pkg.sv
// Shared types and constants for the int8 batch-norm requantizer.
`timescale 1ns / 1ps
`default_nettype none

package bnrq_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	// unused kind: accepted and ignored
	localparam logic [1:0] REQ_NONE   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_LAYOUT  = 3'd0;
	localparam logic [2:0] CFG_PLAIN   = 3'd1;
	localparam logic [2:0] CFG_CHANNEL = 3'd2;
	localparam logic [2:0] CFG_ROW     = 3'd3;
	localparam logic [2:0] CFG_COLUMN  = 3'd4;
	localparam logic [2:0] CFG_BATCH   = 3'd5;
	localparam logic [2:0] CFG_SCALE   = 3'd6;
	localparam logic [2:0] CFG_ZP      = 3'd7;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// element count of a full tensor: 16 * 256 * 4096 * 4096
	localparam int TOT_W = 37;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_MUL1,
		S_LD_MUL2,
		S_LD_WR,
		S_SM_LO,
		S_SM_HI,
		S_SM_WR,
		S_RD_PREP,
		S_RD_DIV,
		S_RD_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/int8_batchnorm_requantize.sv
// Top level of the int8 batch-norm requantizer: coefficient tables, value buffer, datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Signals                          Content
// s        s_tvalid s_tready s_tdata s_tuser requests: load, sample, read
// m        m_tvalid m_tready m_tdata m_tuser results of read requests
//          m_tlast
// cfg      cfg_we cfg_index cfg_data        register writes, no wait
//
// A load and a sample both go through the one shared 32x32 multiplier.
// A read takes one buffer read, one setup step and 8 steps of the restoring
// quotient unit, plus output wait.
// A register write stalls the request side while the tensor size
// products settle. Reset clears the stream state; tables and buffer hold
// garbage until written. The request side accepts while a result waits.
module int8_batchnorm_requantize #(
	parameter int MAX_CHANNELS = 256,
	parameter int BUFFER_DEPTH = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// channel_index[7:0] mean_term[39:8] variance_term[71:40]
	// gamma_term[103:72] beta_term[135:104] sample[143:136]
	input  wire logic [143:0] s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// quantized_value[7:0] output_scale[39:8]
	output logic [39:0]       m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser,
	// last_flag
	output logic              m_tlast,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int TD  = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;
	localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
	localparam int AW  = $clog2(BUFFER_DEPTH);
	localparam int PW  = $clog2(BUFFER_DEPTH + 1);
	localparam logic [8:0] CH_HI = 9'(TD);
	localparam logic [bnrq_pkg::TOT_W-1:0] DEPTH_T = bnrq_pkg::TOT_W'(BUFFER_DEPTH);

	// round half away at bit 16 and cap the magnitude at 2^40
	function automatic logic [40:0] rnd_cap(input logic [72:0] p);
		logic [72:0] r;
		begin
			r = p + 73'h8000;
			if (r[72:16] > 57'h100_0000_0000)
				rnd_cap = 41'h100_0000_0000;
			else
				rnd_cap = r[56:16];
		end
	endfunction

	// saturate a 43-bit signed value to signed 32 bits
	function automatic logic [31:0] sat32(input logic signed [42:0] v);
		begin
			if (v > 43'sh0_7FFF_FFFF)
				sat32 = 32'h7FFF_FFFF;
			else if (v < -43'sh0_8000_0000)
				sat32 = 32'h8000_0000;
			else
				sat32 = v[31:0];
		end
	endfunction

	// configuration registers
	logic        layout_q, plain_q;
	logic [8:0]  chan_cnt_q;
	logic [12:0] row_cnt_q, col_cnt_q;
	logic [4:0]  batch_cnt_q;
	logic [31:0] in_scale_q;
	logic [7:0]  in_zp_q;
	logic [1:0]  settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q    <= 1'b0;
			plain_q     <= 1'b0;
			chan_cnt_q  <= 9'd1;
			row_cnt_q   <= 13'd1;
			col_cnt_q   <= 13'd1;
			batch_cnt_q <= 5'd1;
			in_scale_q  <= 32'd65536;
			in_zp_q     <= 8'd0;
			settle_q    <= 2'd3;
		end else if (cfg_we) begin
			settle_q <= 2'd3;
			case (cfg_index)
				bnrq_pkg::CFG_LAYOUT:  layout_q    <= cfg_data[0];
				bnrq_pkg::CFG_PLAIN:   plain_q     <= cfg_data[0];
				bnrq_pkg::CFG_CHANNEL: chan_cnt_q  <= cfg_data[8:0];
				bnrq_pkg::CFG_ROW:     row_cnt_q   <= cfg_data[12:0];
				bnrq_pkg::CFG_COLUMN:  col_cnt_q   <= cfg_data[12:0];
				bnrq_pkg::CFG_BATCH:   batch_cnt_q <= cfg_data[4:0];
				bnrq_pkg::CFG_SCALE:   in_scale_q  <= cfg_data;
				bnrq_pkg::CFG_ZP:      in_zp_q     <= cfg_data[7:0];
				default: ;
			endcase
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// clamped sizes
	logic [8:0]  nch;
	logic [12:0] rows_c, cols_c;
	logic [4:0]  batch_c;
	always_comb begin
		nch     = (chan_cnt_q == 9'd0) ? 9'd1 : ((chan_cnt_q > CH_HI) ? CH_HI : chan_cnt_q);
		rows_c  = (row_cnt_q == 13'd0) ? 13'd1 :
			((row_cnt_q > 13'd4096) ? 13'd4096 : row_cnt_q);
		cols_c  = (col_cnt_q == 13'd0) ? 13'd1 :
			((col_cnt_q > 13'd4096) ? 13'd4096 : col_cnt_q);
		batch_c = (batch_cnt_q == 5'd0) ? 5'd1 :
			((batch_cnt_q > 5'd16) ? 5'd16 : batch_cnt_q);
	end

	// tensor size products, two stages
	logic [24:0]                 plane_s1;
	logic [12:0]                 bc_s1;
	logic [bnrq_pkg::TOT_W-1:0]  total_s2;
	always_ff @(posedge clk) begin
		plane_s1 <= 25'(rows_c * cols_c);
		bc_s1    <= 13'(batch_c * nch);
		total_s2 <= bnrq_pkg::TOT_W'(bc_s1 * plane_s1);
	end

	// state
	bnrq_pkg::state_t state_q, state_n;
	logic [143:0] req_q;
	logic [2:0]   cnt_q;

	logic [PW-1:0] wr_pos_q, rd_pos_q;
	logic [7:0]    ch_pos_q, ch_eff_q;
	logic [23:0]   pix_pos_q, pix_eff_q;
	logic [39:0]   max_q;
	logic          ovf_q;

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	logic accept;
	assign s_tready = (state_q == bnrq_pkg::S_IDLE) && (settle_q == 2'd0);
	assign accept   = s_tvalid && s_tready;

	logic rd_avail;
	assign rd_avail = rd_pos_q < wr_pos_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			bnrq_pkg::S_IDLE: begin
				if (accept) begin
					case (s_tuser)
						bnrq_pkg::REQ_LOAD:
							if (s_tdata[7:0] < 8'(TD - 1) || s_tdata[7:0] == 8'(TD - 1))
								state_n = bnrq_pkg::S_LD_MUL1;
						bnrq_pkg::REQ_SAMPLE: state_n = bnrq_pkg::S_SM_LO;
						bnrq_pkg::REQ_READ:
							if (rd_avail)
								state_n = bnrq_pkg::S_RD_PREP;
						default: ;
					endcase
				end
			end
			bnrq_pkg::S_LD_MUL1: state_n = bnrq_pkg::S_LD_MUL2;
			bnrq_pkg::S_LD_MUL2: state_n = bnrq_pkg::S_LD_WR;
			bnrq_pkg::S_LD_WR:   state_n = bnrq_pkg::S_IDLE;
			bnrq_pkg::S_SM_LO:   state_n = bnrq_pkg::S_SM_HI;
			bnrq_pkg::S_SM_HI:   state_n = bnrq_pkg::S_SM_WR;
			bnrq_pkg::S_SM_WR:   state_n = bnrq_pkg::S_IDLE;
			bnrq_pkg::S_RD_PREP: state_n = bnrq_pkg::S_RD_DIV;
			bnrq_pkg::S_RD_DIV:
				if (cnt_q == 3'd0)
					state_n = bnrq_pkg::S_RD_OUT;
			bnrq_pkg::S_RD_OUT:
				if (out_free)
					state_n = bnrq_pkg::S_IDLE;
			default: state_n = bnrq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bnrq_pkg::S_IDLE;
		else
			state_q <= state_n;
	end

	// request fields
	logic [7:0]  f_ch;
	logic [31:0] f_mean, f_var, f_gam, f_bet;
	assign f_ch   = req_q[7:0];
	assign f_mean = req_q[39:8];
	assign f_var  = req_q[71:40];
	assign f_gam  = req_q[103:72];
	assign f_bet  = req_q[135:104];

	// normalized positions for a new sample
	logic [7:0]  ch_eff;
	logic [23:0] pix_eff;
	always_comb begin
		ch_eff  = ({1'b0, ch_pos_q} >= nch) ? 8'd0 : ch_pos_q;
		pix_eff = ({1'b0, pix_pos_q} >= plane_s1) ? 24'd0 : pix_pos_q;
	end

	// coefficient tables
	logic [31:0] scale_mem [TD];
	logic [31:0] off_mem   [TD];
	logic [31:0] tab_scale_rd, tab_off_rd;
	logic [31:0] ld_scale_q;
	logic [31:0] ld_off;

	always_ff @(posedge clk) begin
		if (state_q == bnrq_pkg::S_LD_WR) begin
			scale_mem[f_ch[TAW-1:0]] <= plain_q ? f_var : ld_scale_q;
			off_mem[f_ch[TAW-1:0]]   <= plain_q ? f_mean : ld_off;
		end
		if (accept && s_tuser == bnrq_pkg::REQ_SAMPLE) begin
			tab_scale_rd <= scale_mem[ch_eff[TAW-1:0]];
			tab_off_rd   <= off_mem[ch_eff[TAW-1:0]];
		end
	end

	// value buffer
	logic [39:0] buf_mem [BUFFER_DEPTH];
	logic [39:0] buf_rd;
	logic        buf_we;
	logic [39:0] v_new;

	always_ff @(posedge clk) begin
		if (buf_we)
			buf_mem[wr_pos_q[AW-1:0]] <= v_new;
		if (accept && s_tuser == bnrq_pkg::REQ_READ)
			buf_rd <= buf_mem[rd_pos_q[AW-1:0]];
	end

	// shared 32x32 magnitude multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [39:0] data_mag_q;
	logic        data_neg_q;
	logic [31:0] tab_scale_mag;
	assign tab_scale_mag = tab_scale_rd[31] ? (32'd0 - tab_scale_rd) : tab_scale_rd;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		mag32 = x[31] ? (32'd0 - x) : x;
	endfunction

	always_comb begin
		case (state_q)
			bnrq_pkg::S_LD_MUL1: begin
				mul_a = mag32(f_gam);
				mul_b = mag32(f_var);
			end
			bnrq_pkg::S_LD_MUL2: begin
				mul_a = mag32(f_gam);
				mul_b = mag32(f_mean);
			end
			bnrq_pkg::S_SM_LO: begin
				mul_a = {8'd0, data_mag_q[23:0]};
				mul_b = tab_scale_mag;
			end
			default: begin
				mul_a = {16'd0, data_mag_q[39:24]};
				mul_b = tab_scale_mag;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// load folding from the registered product
	logic [72:0] prod_q;
	logic [40:0] ld_m;
	logic        ld_neg;
	logic signed [42:0] ld_sm;
	always_comb begin
		ld_m   = rnd_cap(prod_q);
		ld_neg = f_gam[31] ^ ((state_q == bnrq_pkg::S_LD_MUL2) ? f_var[31] : f_mean[31]);
		ld_sm  = ld_neg ? -$signed({2'b00, ld_m}) : $signed({2'b00, ld_m});
		ld_off = sat32(ld_sm + 43'($signed(f_bet)));
	end

	// sample value from the accumulated product
	logic [40:0] sm_m;
	logic signed [42:0] sm_v;
	logic        in_limit;
	always_comb begin
		sm_m = rnd_cap(prod_q);
		sm_v = ((data_neg_q ^ tab_scale_rd[31]) ? -$signed({2'b00, sm_m}) :
			$signed({2'b00, sm_m})) + 43'($signed(tab_off_rd));
		if (sm_v > 43'sh07F_FFFF_FFFF)
			v_new = 40'h7F_FFFF_FFFF;
		else if (sm_v < -43'sh080_0000_0000)
			v_new = 40'h80_0000_0000;
		else
			v_new = sm_v[39:0];
		in_limit = (bnrq_pkg::TOT_W'(wr_pos_q) < total_s2) &&
			(bnrq_pkg::TOT_W'(wr_pos_q) < DEPTH_T);
		buf_we = (state_q == bnrq_pkg::S_SM_WR) && in_limit;
	end

	logic [39:0] v_new_mag;
	assign v_new_mag = v_new[39] ? (40'd0 - v_new) : v_new;

	// position advance
	logic [8:0]  ch_inc;
	logic [24:0] pix_inc;
	logic [7:0]  ch_next;
	logic [23:0] pix_next;
	always_comb begin
		ch_inc  = {1'b0, ch_eff_q} + 9'd1;
		pix_inc = {1'b0, pix_eff_q} + 25'd1;
		ch_next  = ch_eff_q;
		pix_next = pix_eff_q;
		if (!layout_q) begin
			if (pix_inc >= plane_s1) begin
				pix_next = 24'd0;
				ch_next  = (ch_inc >= nch) ? 8'd0 : ch_inc[7:0];
			end else begin
				pix_next = pix_inc[23:0];
			end
		end else begin
			if (ch_inc >= nch) begin
				ch_next  = 8'd0;
				pix_next = (pix_inc >= plane_s1) ? 24'd0 : pix_inc[23:0];
			end else begin
				ch_next = ch_inc[7:0];
			end
		end
	end

	// read path: quotient unit and output scale
	logic [48:0] num_q;
	logic [40:0] den_q;
	logic [7:0]  quot_q;
	logic        vneg_q;
	logic [40:0] x_q;
	logic [33:0] sc_q;
	logic [9:0]  rem_q;
	logic [48:0] den_sh;
	logic        div_ge;
	logic [40:0] sc_full;
	logic [39:0] rd_mag;
	logic [40:0] x_new;
	logic [40:0] q0_sum;
	always_comb begin
		den_sh  = {8'd0, den_q} << cnt_q;
		div_ge  = num_q >= den_sh;
		sc_full = x_q - (({7'd0, sc_q} << 7) - {7'd0, sc_q});
		rd_mag  = buf_rd[39] ? (40'd0 - buf_rd) : buf_rd;
		x_new   = {1'b0, max_q} + 41'd63;
		q0_sum  = (x_new >> 7) + (x_new >> 14) + (x_new >> 21) + (x_new >> 28) + (x_new >> 35);
	end

	// result fields
	logic [6:0]  qm;
	logic [7:0]  q_out;
	logic [31:0] sc_out;
	logic        last;
	logic [1:0]  status;
	always_comb begin
		qm    = (quot_q > 8'd127) ? 7'd127 : quot_q[6:0];
		q_out = vneg_q ? (8'd0 - {1'b0, qm}) : {1'b0, qm};
		sc_out = (sc_q > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sc_q[31:0];
		if (max_q == 40'd0) begin
			q_out  = 8'd0;
			sc_out = 32'd0;
		end
		last = (rd_pos_q + PW'(1)) == wr_pos_q;
		if (ovf_q)
			status = bnrq_pkg::ST_OVERFLOW;
		else if (bnrq_pkg::TOT_W'(wr_pos_q) < total_s2)
			status = bnrq_pkg::ST_SHORT;
		else
			status = bnrq_pkg::ST_OK;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= s_tdata;
			data_mag_q <= 40'(in_scale_q * 8'(($signed({s_tdata[143], s_tdata[143:136]}) -
				$signed({in_zp_q[7], in_zp_q})) < 0 ?
				-($signed({s_tdata[143], s_tdata[143:136]}) - $signed({in_zp_q[7], in_zp_q})) :
				($signed({s_tdata[143], s_tdata[143:136]}) - $signed({in_zp_q[7], in_zp_q}))));
			data_neg_q <= ($signed({s_tdata[143], s_tdata[143:136]}) -
				$signed({in_zp_q[7], in_zp_q})) < 0;
			ch_eff_q  <= ch_eff;
			pix_eff_q <= pix_eff;
		end
		case (state_q)
			bnrq_pkg::S_LD_MUL1: prod_q <= {9'd0, mul_p};
			bnrq_pkg::S_LD_MUL2: begin
				ld_scale_q <= sat32(ld_sm);
				prod_q     <= {9'd0, mul_p};
			end
			bnrq_pkg::S_SM_LO: prod_q <= {9'd0, mul_p};
			bnrq_pkg::S_SM_HI: prod_q <= prod_q + ({9'd0, mul_p} << 24);
			bnrq_pkg::S_RD_PREP: begin
				num_q  <= ({9'd0, rd_mag} << 8) - ({9'd0, rd_mag} << 1) + {9'd0, max_q};
				den_q  <= {max_q, 1'b0};
				quot_q <= 8'd0;
				vneg_q <= buf_rd[39];
				x_q    <= x_new;
				sc_q   <= q0_sum[33:0];
				cnt_q  <= 3'd7;
			end
			bnrq_pkg::S_RD_DIV: begin
				if (div_ge) begin
					num_q         <= num_q - den_sh;
					quot_q[cnt_q] <= 1'b1;
				end
				cnt_q <= cnt_q - 3'd1;
				// remainder of the scale estimate, then unit corrections
				if (cnt_q == 3'd7) begin
					rem_q <= sc_full[9:0];
				end else if (rem_q >= 10'd127) begin
					rem_q <= rem_q - 10'd127;
					sc_q  <= sc_q + 34'd1;
				end
			end
			default: ;
		endcase
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q  <= '0;
			rd_pos_q  <= '0;
			ch_pos_q  <= 8'd0;
			pix_pos_q <= 24'd0;
			max_q     <= 40'd0;
			ovf_q     <= 1'b0;
		end else if (state_q == bnrq_pkg::S_SM_WR) begin
			if (in_limit) begin
				wr_pos_q <= wr_pos_q + PW'(1);
				if (v_new_mag > max_q)
					max_q <= v_new_mag;
			end else begin
				ovf_q <= 1'b1;
			end
			ch_pos_q  <= ch_next;
			pix_pos_q <= pix_next;
		end else if (state_q == bnrq_pkg::S_RD_OUT && out_free) begin
			if (last) begin
				wr_pos_q  <= '0;
				rd_pos_q  <= '0;
				ch_pos_q  <= 8'd0;
				pix_pos_q <= 24'd0;
				max_q     <= 40'd0;
				ovf_q     <= 1'b0;
			end else begin
				rd_pos_q <= rd_pos_q + PW'(1);
			end
		end
	end

	// output register
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic [1:0]  out_user_q;
	logic        out_last_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == bnrq_pkg::S_RD_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == bnrq_pkg::S_RD_OUT && out_free) begin
			out_data_q <= {sc_out, q_out};
			out_user_q <= status;
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire
